// ===== rtl/rbas_pkg.sv =====
// Shared types, sizes and command codes for the RGB LED bit-angle scanner.
// Used by every module in the rtl folder; has no dependencies of its own.
package rbas_pkg;

    localparam int LED_COUNT   = 16;
    localparam int PLANE_COUNT = 8;
    localparam int GRID_ROWS   = 4;

    localparam int LED_COLS  = ((LED_COUNT / GRID_ROWS) > 0) ? (LED_COUNT / GRID_ROWS) : 1;
    localparam int ROW_COUNT = ((LED_COUNT - 1) / LED_COLS) + 1;

    localparam int IDX_W   = $clog2(LED_COUNT);
    localparam int ROW_W   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int COL_W   = (LED_COLS > 1) ? $clog2(LED_COLS) : 1;
    localparam int PLANE_W = $clog2(PLANE_COUNT + 1);

    localparam int CMD_W    = 3;
    localparam int LED_W    = 4;
    localparam int CH_W     = 8;
    localparam int LEVEL_W  = 9;
    localparam int COLOR_W  = 3 * CH_W;
    localparam int SHIFT_W  = 12;
    localparam int HOLD_W   = 8;
    localparam int COLSEL_W = 4;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_SET_COLOR = 3'd1,
        CMD_SET_LEVEL = 3'd2,
        CMD_ON        = 3'd3,
        CMD_OFF       = 3'd4,
        CMD_ON_CL     = 3'd5,
        CMD_OFF_CL    = 3'd6,
        CMD_QUERY     = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_UPDATE,
        S_EMIT,
        S_REPLY
    } t_state;

    // Selects which kind of output word the formatter builds.
    typedef struct packed {
        logic                reply;
        logic                blank;
        logic [PLANE_W-1:0]  plane;
    } t_word_ctl;

    typedef struct packed {
        logic                reply_kind;
        logic [COLSEL_W-1:0] column_select;
        logic [SHIFT_W-1:0]  shift_word;
        logic [HOLD_W-1:0]   hold_weight;
        logic                last;
        logic [CH_W-1:0]     red;
        logic [CH_W-1:0]     green;
        logic [CH_W-1:0]     blue;
        logic [LEVEL_W-1:0]  level;
        logic                is_on;
    } t_result;

endpackage

// ===== rtl/rbas_lane.sv =====
// One colour channel lane: scales a channel by a Q1.8 level and saturates.
// Depends on rbas_pkg; three copies run side by side in the top level.
module rbas_lane import rbas_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [CH_W-1:0]    i_channel,
    input  logic [LEVEL_W-1:0] i_level,
    output logic [CH_W-1:0]    o_scaled
);

    logic [CH_W+LEVEL_W-1:0] s_prod;
    logic [LEVEL_W-1:0]      s_shift;
    logic [CH_W-1:0]         n_scaled;
    logic [CH_W-1:0]         r_scaled;

    always_comb begin
        s_prod  = {{LEVEL_W{1'b0}}, i_channel} * {{CH_W{1'b0}}, i_level};
        s_shift = s_prod[CH_W+LEVEL_W-1:CH_W];
        // Levels above 1.0 can push the product past full scale.
        if (s_shift[LEVEL_W-1:CH_W] != '0) begin
            n_scaled = '1;
        end else begin
            n_scaled = s_shift[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scaled <= n_scaled;
        end
    end

    assign o_scaled = r_scaled;

endmodule

// ===== rtl/rbas_word.sv =====
// Output word formatter: builds a plane word, the blank word or a query reply.
// Depends on rbas_pkg; driven by the sequencer in the top level.
module rbas_word import rbas_pkg::*; (
    input  t_word_ctl           i_ctl,
    input  logic [COLOR_W-1:0]  i_shown,
    input  logic [ROW_W-1:0]    i_row,
    input  logic [COL_W-1:0]    i_col,
    input  logic                i_hit,
    input  logic [COLOR_W-1:0]  i_color,
    input  logic [LEVEL_W-1:0]  i_level,
    input  logic                i_lit,
    output t_result             o_result
);

    logic [2:0]          s_plane;
    logic [SHIFT_W-1:0]  s_word;
    logic [COLSEL_W-1:0] s_sel;

    assign s_plane = 3'(i_ctl.plane);

    // Channel c of the scanned LED lands at bit 3*row+c; bits past the word are dropped.
    always_comb begin
        s_word = '0;
        for (int j = 0; j < SHIFT_W; j++) begin
            for (int c = 0; c < 3; c++) begin
                if ((32'(i_row) * 3 + c) == j) begin
                    s_word[j] = i_shown[CH_W * c + int'(s_plane)];
                end
            end
        end
    end

    always_comb begin
        s_sel = '0;
        for (int k = 0; k < COLSEL_W; k++) begin
            s_sel[k] = (32'(i_col) == k);
        end
    end

    always_comb begin
        o_result = '0;
        if (i_ctl.reply) begin
            o_result.reply_kind = 1'b1;
            if (i_hit) begin
                o_result.red   = i_color[CH_W-1:0];
                o_result.green = i_color[2*CH_W-1:CH_W];
                o_result.blue  = i_color[3*CH_W-1:2*CH_W];
                o_result.level = i_level;
                o_result.is_on = i_lit;
            end
        end else begin
            o_result.column_select = s_sel;
            if (i_ctl.blank) begin
                o_result.last = 1'b1;
            end else begin
                o_result.shift_word  = s_word;
                o_result.hold_weight = HOLD_W'(1) << s_plane;
            end
        end
    end

endmodule

// ===== rtl/rgb_led_bit_angle_scanner.sv =====
// A tick gives its plane words from the emit state, one word a cycle while the output is not
// stalled, PLANE_COUNT+1 words in all; the input is held off until the tick is done.
// A query reply is loaded from the reply state; a write passes the scale state, where the
// three channel lanes register their scaled values, then the update state that stores them.
// Output stalls stretch ticks and replies. Synchronous active-low reset restores all LED
// state (colour 0, level 1.0, off) and the scan position.
module rgb_led_bit_angle_scanner import rbas_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [LED_W-1:0]   i_led,
    input  logic [CH_W-1:0]    i_red_in,
    input  logic [CH_W-1:0]    i_green_in,
    input  logic [CH_W-1:0]    i_blue_in,
    input  logic [LEVEL_W-1:0] i_level_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_reply_kind,
    output logic [COLSEL_W-1:0] o_column_select,
    output logic [SHIFT_W-1:0] o_shift_word,
    output logic [HOLD_W-1:0]  o_hold_weight,
    output logic               o_last,
    output logic [CH_W-1:0]    o_red_out,
    output logic [CH_W-1:0]    o_green_out,
    output logic [CH_W-1:0]    o_blue_out,
    output logic [LEVEL_W-1:0] o_level_out,
    output logic               o_is_on
);

    t_state r_state;
    t_state n_state;

    t_cmd               r_cmd;
    logic [IDX_W-1:0]   r_idx;
    logic               r_hit;
    logic [COLOR_W-1:0] r_color_in;
    logic [LEVEL_W-1:0] r_level_in;

    logic [COLOR_W-1:0] r_color [LED_COUNT];
    logic [LEVEL_W-1:0] r_level [LED_COUNT];
    logic [LED_COUNT-1:0] r_lit;
    logic [COLOR_W-1:0] r_shown [LED_COUNT];

    logic [IDX_W-1:0]   r_scan_pos;
    logic [ROW_W-1:0]   r_scan_row;
    logic [COL_W-1:0]   r_scan_col;
    logic [PLANE_W-1:0] r_plane;

    t_result r_out;
    logic    r_out_valid;

    logic s_in_hit;
    logic s_accept;
    logic s_out_free;
    logic s_scale_en;
    logic s_commit;
    logic s_load;
    logic s_blank;

    logic [COLOR_W-1:0] s_lane_color;
    logic [LEVEL_W-1:0] s_lane_level;
    logic [CH_W-1:0]    s_red_sc;
    logic [CH_W-1:0]    s_green_sc;
    logic [CH_W-1:0]    s_blue_sc;
    logic [COLOR_W-1:0] s_new_shown;

    t_word_ctl s_ctl;
    t_result   s_word;

    assign s_in_hit   = (32'(i_led) < LED_COUNT);
    assign s_out_free = !r_out_valid || !i_stall;
    assign s_blank    = (r_plane == PLANE_W'(PLANE_COUNT));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (t_cmd'(i_command) == CMD_TICK) begin
                        n_state = S_EMIT;
                    end else if (t_cmd'(i_command) == CMD_QUERY) begin
                        n_state = S_REPLY;
                    end else if (s_in_hit) begin
                        n_state = S_SCALE;
                    end
                end
            end
            S_SCALE:  n_state = S_UPDATE;
            S_UPDATE: n_state = S_IDLE;
            S_EMIT: begin
                if (s_out_free && s_blank) begin
                    n_state = S_IDLE;
                end
            end
            S_REPLY: begin
                if (s_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_stall    = 1'b1;
        s_scale_en = 1'b0;
        s_commit   = 1'b0;
        s_load     = 1'b0;
        case (r_state)
            S_IDLE:   o_stall = 1'b0;
            S_SCALE:  s_scale_en = 1'b1;
            S_UPDATE: s_commit = 1'b1;
            S_EMIT:   s_load = s_out_free;
            S_REPLY:  s_load = s_out_free;
            default:  o_stall = 1'b1;
        endcase
    end

    assign s_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd      <= t_cmd'(i_command);
            r_idx      <= IDX_W'(i_led);
            r_hit      <= s_in_hit;
            r_color_in <= {i_blue_in, i_green_in, i_red_in};
            r_level_in <= i_level_in;
        end
    end

    // The commands that carry a colour or a level scale with it; the rest use the stored one.
    always_comb begin
        if (r_cmd == CMD_SET_COLOR || r_cmd == CMD_ON_CL || r_cmd == CMD_OFF_CL) begin
            s_lane_color = r_color_in;
        end else begin
            s_lane_color = r_color[r_idx];
        end
        if (r_cmd == CMD_SET_LEVEL || r_cmd == CMD_ON_CL || r_cmd == CMD_OFF_CL) begin
            s_lane_level = r_level_in;
        end else begin
            s_lane_level = r_level[r_idx];
        end
    end

    rbas_lane u_lane_red (
        .i_clk     (i_clk),
        .i_en      (s_scale_en),
        .i_channel (s_lane_color[CH_W-1:0]),
        .i_level   (s_lane_level),
        .o_scaled  (s_red_sc)
    );

    rbas_lane u_lane_green (
        .i_clk     (i_clk),
        .i_en      (s_scale_en),
        .i_channel (s_lane_color[2*CH_W-1:CH_W]),
        .i_level   (s_lane_level),
        .o_scaled  (s_green_sc)
    );

    rbas_lane u_lane_blue (
        .i_clk     (i_clk),
        .i_en      (s_scale_en),
        .i_channel (s_lane_color[3*CH_W-1:2*CH_W]),
        .i_level   (s_lane_level),
        .o_scaled  (s_blue_sc)
    );

    assign s_new_shown = {s_blue_sc, s_green_sc, s_red_sc};

    // LED state update; write items only reach here with an LED number in range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                r_color[i] <= '0;
                r_level[i] <= LEVEL_FULL;
                r_shown[i] <= '0;
            end
            r_lit <= '0;
        end else if (s_commit) begin
            case (r_cmd)
                CMD_SET_COLOR: begin
                    r_color[r_idx] <= r_color_in;
                    if (r_lit[r_idx]) begin
                        r_shown[r_idx] <= s_new_shown;
                    end
                end
                CMD_SET_LEVEL: begin
                    r_level[r_idx] <= r_level_in;
                    if (r_lit[r_idx]) begin
                        r_shown[r_idx] <= s_new_shown;
                    end
                end
                CMD_ON: begin
                    if (!r_lit[r_idx]) begin
                        r_shown[r_idx] <= s_new_shown;
                        r_lit[r_idx]   <= 1'b1;
                    end
                end
                CMD_OFF: begin
                    if (r_lit[r_idx]) begin
                        r_shown[r_idx] <= '0;
                        r_lit[r_idx]   <= 1'b0;
                    end
                end
                CMD_ON_CL: begin
                    r_color[r_idx] <= r_color_in;
                    r_level[r_idx] <= r_level_in;
                    r_shown[r_idx] <= s_new_shown;
                    r_lit[r_idx]   <= 1'b1;
                end
                CMD_OFF_CL: begin
                    r_color[r_idx] <= r_color_in;
                    r_level[r_idx] <= r_level_in;
                    r_shown[r_idx] <= '0;
                    r_lit[r_idx]   <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Scan position is kept as row and column alongside the linear index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_pos <= '0;
            r_scan_row <= '0;
            r_scan_col <= '0;
        end else if (s_load && r_state == S_EMIT && s_blank) begin
            if (r_scan_pos == IDX_W'(LED_COUNT - 1)) begin
                r_scan_pos <= '0;
                r_scan_row <= '0;
                r_scan_col <= '0;
            end else begin
                r_scan_pos <= r_scan_pos + 1'b1;
                if (r_scan_col == COL_W'(LED_COLS - 1)) begin
                    r_scan_col <= '0;
                    r_scan_row <= r_scan_row + 1'b1;
                end else begin
                    r_scan_col <= r_scan_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (s_accept) begin
            r_plane <= '0;
        end else if (s_load && r_state == S_EMIT && !s_blank) begin
            r_plane <= r_plane + 1'b1;
        end
    end

    assign s_ctl.reply = (r_state == S_REPLY);
    assign s_ctl.blank = s_blank;
    assign s_ctl.plane = r_plane;

    rbas_word u_word (
        .i_ctl    (s_ctl),
        .i_shown  (r_shown[r_scan_pos]),
        .i_row    (r_scan_row),
        .i_col    (r_scan_col),
        .i_hit    (r_hit),
        .i_color  (r_color[r_idx]),
        .i_level  (r_level[r_idx]),
        .i_lit    (r_lit[r_idx]),
        .o_result (s_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_out <= s_word;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_reply_kind    = r_out.reply_kind;
    assign o_column_select = r_out.column_select;
    assign o_shift_word    = r_out.shift_word;
    assign o_hold_weight   = r_out.hold_weight;
    assign o_last          = r_out.last;
    assign o_red_out       = r_out.red;
    assign o_green_out     = r_out.green;
    assign o_blue_out      = r_out.blue;
    assign o_level_out     = r_out.level;
    assign o_is_on         = r_out.is_on;

    a_blank_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_shift_word == '0 && o_hold_weight == '0 && !o_reply_kind))
        else $error("blank word carries plane data");

    a_reply_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reply_kind) |-> (o_column_select == '0 && !o_last))
        else $error("query reply carries scan fields");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_scan_pos) < LED_COUNT))
        else $error("scan position out of range");

    a_plane_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (32'(r_plane) <= PLANE_COUNT && o_stall))
        else $error("plane counter overran during refresh");

endmodule
